### rtl/core/ptcd_pkg.sv
// Shared types and constants for the clamped PID drive block.
// Holds field widths, fixed-point scales, register indexes and the configuration struct.
// No dependencies; every other file of the block but ptcd_cdiv refers to it by scoped names.
package ptcd_pkg;

  localparam int ANGLE_W    = 8;
  localparam int GAIN_W     = 12;
  localparam int LEVEL_W    = 22;
  localparam int ACC_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Fixed-point scales: results are in units of 1/10000.
  localparam int DRIVE_SCALE = 10000;
  localparam int P_SCALE     = 100;
  localparam int D_SCALE     = 100000;
  localparam int I_DIV       = 10;

  // Integral gains below this raw value clear the accumulator.
  localparam int I_GAIN_MIN = 2;

  // Reset values of the configuration registers, whole units.
  localparam int SETPOINT_RST = 0;
  localparam int REST_RST     = 190;
  localparam int UPPER_RST    = 200;
  localparam int LOWER_RST    = 180;
  localparam int BOUND_RST    = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_REST     = 3'd1,
    REG_UPPER    = 3'd2,
    REG_LOWER    = 3'd3,
    REG_BOUND    = 3'd4
  } cfg_reg_e;

  // Drive-related registers are held already scaled by DRIVE_SCALE.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] setpoint;
    logic [LEVEL_W-1:0]        rest_s;
    logic [LEVEL_W-1:0]        upper_s;
    logic [LEVEL_W-1:0]        lower_s;
    logic [LEVEL_W-1:0]        bound_s;
  } cfg_t;

endpackage

### rtl/core/ptcd_in_if.sv
// Input channel of the clamped PID drive: one angle sample and three raw gains per beat.
// Depends on ptcd_pkg for the field widths.
interface ptcd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptcd_pkg::ANGLE_W-1:0] angle_deg;
  logic [ptcd_pkg::GAIN_W-1:0]         p_gain_raw;
  logic [ptcd_pkg::GAIN_W-1:0]         i_gain_raw;
  logic [ptcd_pkg::GAIN_W-1:0]         d_gain_raw;

  modport source (output valid, angle_deg, p_gain_raw, i_gain_raw, d_gain_raw, input ready);
  modport sink (input valid, angle_deg, p_gain_raw, i_gain_raw, d_gain_raw, output ready);
endinterface

### rtl/core/ptcd_out_if.sv
// Output channel of the clamped PID drive: one drive level and clamp flag per beat.
// Depends on ptcd_pkg for the field widths.
interface ptcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ptcd_pkg::LEVEL_W-1:0] drive_level;
  logic                         drive_clamped;

  modport source (output valid, drive_level, drive_clamped, input ready);
  modport sink (input valid, drive_level, drive_clamped, output ready);
endinterface

### rtl/core/ptcd_cfg_regs.sv
// Configuration register file of the clamped PID drive, written through a plain write port.
// Stores drive-related values pre-scaled to 1/10000 units; depends on ptcd_pkg.
module ptcd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               we,
  input  logic [ptcd_pkg::CFG_IDX_W-1:0]     index,
  input  logic [ptcd_pkg::CFG_DATA_W-1:0]    data,
  output ptcd_pkg::cfg_t                     cfg
);

  logic [ptcd_pkg::LEVEL_W-1:0] scaled;

  assign scaled = ptcd_pkg::LEVEL_W'(data * ptcd_pkg::DRIVE_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint <= ptcd_pkg::ANGLE_W'(ptcd_pkg::SETPOINT_RST);
      cfg.rest_s   <= ptcd_pkg::LEVEL_W'(ptcd_pkg::REST_RST * ptcd_pkg::DRIVE_SCALE);
      cfg.upper_s  <= ptcd_pkg::LEVEL_W'(ptcd_pkg::UPPER_RST * ptcd_pkg::DRIVE_SCALE);
      cfg.lower_s  <= ptcd_pkg::LEVEL_W'(ptcd_pkg::LOWER_RST * ptcd_pkg::DRIVE_SCALE);
      cfg.bound_s  <= ptcd_pkg::LEVEL_W'(ptcd_pkg::BOUND_RST * ptcd_pkg::DRIVE_SCALE);
    end else if (we) begin
      case (index)
        ptcd_pkg::REG_SETPOINT: cfg.setpoint <= $signed(data);
        ptcd_pkg::REG_REST:     cfg.rest_s   <= scaled;
        ptcd_pkg::REG_UPPER:    cfg.upper_s  <= scaled;
        ptcd_pkg::REG_LOWER:    cfg.lower_s  <= scaled;
        ptcd_pkg::REG_BOUND:    cfg.bound_s  <= scaled;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/ptcd_cdiv.sv
// Two-stage unsigned divider by a constant: reciprocal multiply, then one correction step.
// Stage enables come from the surrounding pipeline; no package dependency.
module ptcd_cdiv #(
  parameter int DIVISOR = 10,
  parameter int IN_W    = 24
) (
  input  logic            clk,
  input  logic            en1,
  input  logic            en2,
  input  logic [IN_W-1:0] y,
  output logic [IN_W-1:0] q
);

  // floor(2^IN_W / DIVISOR) underestimates the quotient by at most one.
  localparam logic [IN_W:0]   RECIP = (IN_W+1)'((64'd1 << IN_W) / DIVISOR);
  localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);
  localparam logic [IN_W-1:0] ONE   = IN_W'(1);

  logic [2*IN_W:0]  prod;
  logic [IN_W-1:0]  qa;
  logic [IN_W-1:0]  y_d;
  logic [IN_W-1:0]  back;
  logic [IN_W-1:0]  rem;

  assign prod = y * RECIP;

  always_ff @(posedge clk) begin
    if (en1) begin
      qa  <= prod[2*IN_W-1:IN_W];
      y_d <= y;
    end
  end

  assign back = qa * DIV_C;
  assign rem  = y_d - back;

  always_ff @(posedge clk) begin
    if (en2) begin
      q <= (rem >= DIV_C) ? qa + ONE : qa;
    end
  end

endmodule

### rtl/core/pid_trapezoid_clamped_drive.sv
// Clamped PID drive with trapezoidal integral and anti-windup.
//
// Usage: each beat on the sample channel carries a measured angle and three raw gain
// readings (gain = raw / 100). For every accepted beat exactly one beat leaves on the
// result channel: the drive level rest - (P + I + D), clamped to [lower, upper] and
// given in units of 1/10000, with a flag when the clamp acted. The config port writes
// one register per cycle at which cfg_we is high; it must only be used while no beat
// is in flight.
//
// Beats pass through an 8-stage pipeline: input register, gain products, constant
// products, two divider stages, term assembly, integral update, and the result register.
// Throughput is one beat per cycle while result.ready stays high; the integral register
// closes its loop within a single stage, so back-to-back beats see the accumulator value
// left by the beat before.
//
// Reset (synchronous) clears the previous error and the integral to zero, empties the
// pipeline and loads the register defaults. When the receiver stalls, the pipeline
// closes up its bubbles; sample.ready only drops once all eight stages hold a beat.
module pid_trapezoid_clamped_drive #(
  parameter int STEP_MS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  ptcd_in_if.sink                         sample,
  ptcd_out_if.source                      result,
  input  logic                            cfg_we,
  input  logic [ptcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTG = 8;
  localparam int AW   = ptcd_pkg::ANGLE_W;
  localparam int GW   = ptcd_pkg::GAIN_W;
  localparam int LW   = ptcd_pkg::LEVEL_W;
  localparam int TP   = STEP_MS;

  // The integral increment splits as |ia|*I_A + floor(|ia|*I_B / 10), the derivative
  // as |dd|*D_Q + floor(|dd|*D_R / T).
  localparam int I_A = TP / ptcd_pkg::I_DIV;
  localparam int I_B = TP % ptcd_pkg::I_DIV;
  localparam int D_Q = ptcd_pkg::D_SCALE / TP;
  localparam int D_R = ptcd_pkg::D_SCALE % TP;

  localparam int PE_W  = GW + 1 + AW;
  localparam int P_W   = PE_W + $clog2(ptcd_pkg::P_SCALE);
  localparam int MAG_W = GW + AW;
  localparam int YI_W  = MAG_W + $clog2(ptcd_pkg::I_DIV);
  localparam int TI_W  = MAG_W + $clog2(I_A + 1);
  localparam int YD_W  = MAG_W + $clog2(TP) + 1;
  localparam int TD_W  = MAG_W + $clog2(D_Q + 1);
  localparam int MI_W  = ((TI_W > YI_W) ? TI_W : YI_W) + 1;
  localparam int MD_W  = ((TD_W > YD_W) ? TD_W : YD_W) + 1;
  localparam int IS_W  = MI_W + 1;
  localparam int DS_W  = MD_W + 1;
  localparam int SUM_W = ((ptcd_pkg::ACC_W > IS_W) ? ptcd_pkg::ACC_W : IS_W) + 1;
  localparam int VA_W  = (P_W > DS_W) ? P_W : DS_W;
  localparam int V_W   = ((VA_W > ptcd_pkg::ACC_W) ? VA_W : ptcd_pkg::ACC_W) + 2;

  localparam logic signed [P_W-1:0] P_C   = P_W'(ptcd_pkg::P_SCALE);
  localparam logic [YI_W-1:0]       I_B_C = YI_W'(I_B);
  localparam logic [TI_W-1:0]       I_A_C = TI_W'(I_A);
  localparam logic [YD_W-1:0]       D_R_C = YD_W'(D_R);
  localparam logic [TD_W-1:0]       D_Q_C = TD_W'(D_Q);
  localparam logic [GW-1:0]         I_ON  = GW'(ptcd_pkg::I_GAIN_MIN);
  localparam logic signed [AW-1:0]  E_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0]  E_MIN = {1'b1, {(AW-1){1'b0}}};

  ptcd_pkg::cfg_t cfg;

  ptcd_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Pipeline occupancy and bubble-collapsing flow control.
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_next;
  logic [NSTG-1:0] rdy;
  logic            accept;
  logic            acc_go;

  assign rdy[NSTG-1] = !vld[NSTG-1] || result.ready;

  for (genvar g = 0; g < NSTG - 1; g++) begin : g_rdy
    assign rdy[g] = !vld[g] || rdy[g+1];
  end

  assign sample.ready = rdy[0];
  assign accept       = sample.valid && rdy[0];
  assign vld_next     = (vld & ~rdy) | ({vld[NSTG-2:0], sample.valid} & rdy);
  assign acc_go       = vld[5] && rdy[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // Error at the input, saturated to the angle width.
  logic signed [AW:0]   err_wide;
  logic signed [AW-1:0] err;
  logic signed [AW-1:0] prev_err;

  assign err_wide = (AW+1)'(sample.angle_deg) - (AW+1)'(cfg.setpoint);
  assign err = (err_wide[AW] != err_wide[AW-1]) ? (err_wide[AW] ? E_MIN : E_MAX)
                                                : err_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
    end else if (accept) begin
      prev_err <= err;
    end
  end

  // Stage 1: input register.
  logic signed [AW-1:0] s1_e;
  logic signed [AW-1:0] s1_q;
  logic [GW-1:0]        s1_kp;
  logic [GW-1:0]        s1_ki;
  logic [GW-1:0]        s1_kd;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_e  <= err;
      s1_q  <= prev_err;
      s1_kp <= sample.p_gain_raw;
      s1_ki <= sample.i_gain_raw;
      s1_kd <= sample.d_gain_raw;
    end
  end

  // Stage 2: gain products: P on the signed error, I and D on sign and magnitude of the trapezoid and difference.
  logic signed [AW:0]    sum9;
  logic signed [AW:0]    sum_adj;
  logic signed [AW:0]    avg9;
  logic [AW:0]           avg_abs;
  logic signed [AW:0]    diff9;
  logic [AW:0]           diff_abs;
  logic signed [PE_W-1:0] pe;
  logic [MAG_W-1:0]      iam;
  logic [MAG_W-1:0]      ddm;

  assign sum9     = (AW+1)'(s1_e) + (AW+1)'(s1_q);
  // Adding one to a negative sum makes the shift round towards zero.
  assign sum_adj  = sum9 + $signed({{AW{1'b0}}, sum9[AW]});
  assign avg9     = sum_adj >>> 1;
  assign avg_abs  = avg9[AW] ? -avg9 : avg9;
  assign diff9    = (AW+1)'(s1_e) - (AW+1)'(s1_q);
  assign diff_abs = diff9[AW] ? -diff9 : diff9;
  assign pe       = $signed({1'b0, s1_kp}) * s1_e;
  assign iam      = s1_ki * avg_abs[AW-1:0];
  assign ddm      = s1_kd * diff_abs[AW-1:0];

  logic signed [PE_W-1:0] s2_pe;
  logic [MAG_W-1:0]       s2_iam;
  logic [MAG_W-1:0]       s2_ddm;
  logic                   s2_isg;
  logic                   s2_dsg;
  logic                   s2_ion;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_pe  <= pe;
      s2_iam <= iam;
      s2_ddm <= ddm;
      s2_isg <= avg9[AW];
      s2_dsg <= diff9[AW];
      s2_ion <= (s1_ki >= I_ON);
    end
  end

  // Stage 3: products with the fixed scale and period constants.
  logic signed [P_W-1:0] s3_p;
  logic [YI_W-1:0]       s3_yi;
  logic [TI_W-1:0]       s3_ti;
  logic [YD_W-1:0]       s3_yd;
  logic [TD_W-1:0]       s3_td;
  logic                  s3_isg;
  logic                  s3_dsg;
  logic                  s3_ion;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_p   <= s2_pe * P_C;
      s3_yi  <= s2_iam * I_B_C;
      s3_ti  <= s2_iam * I_A_C;
      s3_yd  <= s2_ddm * D_R_C;
      s3_td  <= s2_ddm * D_Q_C;
      s3_isg <= s2_isg;
      s3_dsg <= s2_dsg;
      s3_ion <= s2_ion;
    end
  end

  // Stages 4 and 5: constant dividers, with the side terms carried alongside.
  logic [YI_W-1:0] qi;
  logic [YD_W-1:0] qd;

  ptcd_cdiv #(
    .DIVISOR (ptcd_pkg::I_DIV),
    .IN_W    (YI_W)
  ) u_div_i (
    .clk (clk),
    .en1 (rdy[3]),
    .en2 (rdy[4]),
    .y   (s3_yi),
    .q   (qi)
  );

  ptcd_cdiv #(
    .DIVISOR (TP),
    .IN_W    (YD_W)
  ) u_div_d (
    .clk (clk),
    .en1 (rdy[3]),
    .en2 (rdy[4]),
    .y   (s3_yd),
    .q   (qd)
  );

  logic signed [P_W-1:0] s4_p;
  logic [TI_W-1:0]       s4_ti;
  logic [TD_W-1:0]       s4_td;
  logic                  s4_isg;
  logic                  s4_dsg;
  logic                  s4_ion;
  logic signed [P_W-1:0] s5_p;
  logic [TI_W-1:0]       s5_ti;
  logic [TD_W-1:0]       s5_td;
  logic                  s5_isg;
  logic                  s5_dsg;
  logic                  s5_ion;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_p   <= s3_p;
      s4_ti  <= s3_ti;
      s4_td  <= s3_td;
      s4_isg <= s3_isg;
      s4_dsg <= s3_dsg;
      s4_ion <= s3_ion;
    end
    if (rdy[4]) begin
      s5_p   <= s4_p;
      s5_ti  <= s4_ti;
      s5_td  <= s4_td;
      s5_isg <= s4_isg;
      s5_dsg <= s4_dsg;
      s5_ion <= s4_ion;
    end
  end

  // Stage 6: assemble the signed integral increment and derivative term.
  logic [MI_W-1:0]        mag_i;
  logic [MD_W-1:0]        mag_d;
  logic signed [IS_W-1:0] inc_pos;
  logic signed [DS_W-1:0] d_pos;

  assign mag_i   = MI_W'(s5_ti) + MI_W'(qi);
  assign mag_d   = MD_W'(s5_td) + MD_W'(qd);
  assign inc_pos = $signed(IS_W'(mag_i));
  assign d_pos   = $signed(DS_W'(mag_d));

  logic signed [P_W-1:0]  s6_p;
  logic signed [IS_W-1:0] s6_inc;
  logic signed [DS_W-1:0] s6_d;
  logic                   s6_ion;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_p   <= s5_p;
      s6_inc <= s5_isg ? -inc_pos : inc_pos;
      s6_d   <= s5_dsg ? -d_pos : d_pos;
      s6_ion <= s5_ion;
    end
  end

  // Stage 7: integral accumulation with symmetric clamp or clearing, and the P and D part of the drive.
  logic signed [ptcd_pkg::ACC_W-1:0] acc;
  logic signed [ptcd_pkg::ACC_W-1:0] acc_next;
  logic signed [SUM_W-1:0]           acc_sum;
  logic signed [SUM_W-1:0]           acc_lim;

  assign acc_sum = SUM_W'(acc) + SUM_W'(s6_inc);
  assign acc_lim = $signed(SUM_W'(cfg.bound_s));

  always_comb begin
    if (!s6_ion) begin
      acc_next = '0;
    end else if (acc_sum > acc_lim) begin
      acc_next = ptcd_pkg::ACC_W'(acc_lim);
    end else if (acc_sum < -acc_lim) begin
      acc_next = ptcd_pkg::ACC_W'(-acc_lim);
    end else begin
      acc_next = ptcd_pkg::ACC_W'(acc_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (acc_go) begin
      acc <= acc_next;
    end
  end

  logic signed [ptcd_pkg::ACC_W-1:0] s7_acc;
  logic signed [V_W-1:0]             s7_part;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_acc  <= acc_next;
      s7_part <= $signed(V_W'(cfg.rest_s)) - V_W'(s6_p) - V_W'(s6_d);
    end
  end

  // Stage 8: final subtraction, clamp and result register.
  logic signed [V_W-1:0] drv;
  logic signed [V_W-1:0] hi;
  logic signed [V_W-1:0] lo;
  logic [LW-1:0]         lvl;
  logic [LW-1:0]         lvl_next;
  logic                  clp;
  logic                  clp_next;

  assign drv = s7_part - V_W'(s7_acc);
  assign hi  = $signed(V_W'(cfg.upper_s));
  assign lo  = $signed(V_W'(cfg.lower_s));

  always_comb begin
    if (drv > hi) begin
      lvl_next = cfg.upper_s;
      clp_next = 1'b1;
    end else if (drv < lo) begin
      lvl_next = cfg.lower_s;
      clp_next = 1'b1;
    end else begin
      lvl_next = drv[LW-1:0];
      clp_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      lvl <= lvl_next;
      clp <= clp_next;
    end
  end

  assign result.valid         = vld[NSTG-1];
  assign result.drive_level   = lvl;
  assign result.drive_clamped = clp;

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    (vld == '0) |-> sample.ready)
    else $error("empty pipeline refused a beat");

  a_int_cleared : assert property (@(posedge clk) disable iff (rst)
    (acc_go && !s6_ion) |=> (acc == '0))
    else $error("integral not cleared for a small integral gain");

  a_int_bounded : assert property (@(posedge clk) disable iff (rst)
    (acc_go && s6_ion) |=>
      (acc <= $signed({1'b0, $past(cfg.bound_s)}) &&
       acc >= -$signed({1'b0, $past(cfg.bound_s)})))
    else $error("integral left its bound after an update");

endmodule

### sim/pid_trapezoid_clamped_drive_tb.sv
// Self-checking testbench for pid_trapezoid_clamped_drive: random sample beats,
// back-pressure and register settings, checked against a cycle-free predictor.
// Depends on ptcd_pkg, ptcd_in_if and ptcd_out_if from the RTL.
`timescale 1ns / 100ps

module pid_trapezoid_clamped_drive_tb;

  localparam int CLK_PERIOD = 4;
  localparam int PERIOD_MS  = 20;
  localparam int LATENCY    = 8;
  localparam longint UNIT   = 10000;

  typedef struct {
    logic signed [7:0] angle;
    logic [11:0]       kp;
    logic [11:0]       ki;
    logic [11:0]       kd;
  } sample_t;

  typedef struct {
    logic [21:0] level;
    logic        clamped;
  } drive_res_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  ptcd_in_if  sample_if ();
  ptcd_out_if result_if ();

  pid_trapezoid_clamped_drive #(
    .STEP_MS(PERIOD_MS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_if),
    .result   (result_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register copies and controller state as the block should hold them.
  logic signed [7:0] setpoint_cfg = 8'sd0;
  logic [7:0]        rest_cfg     = 8'd190;
  logic [7:0]        upper_cfg    = 8'd200;
  logic [7:0]        lower_cfg    = 8'd180;
  logic [7:0]        bound_cfg    = 8'd10;
  longint            err_prev     = 0;
  longint            integ_acc    = 0;

  sample_t    sample_queue[$];
  drive_res_t drive_expected[$];
  sample_t    next_item;
  drive_res_t got_drive;
  drive_res_t want_drive;
  int         send_gap   = 0;
  int         stall_left = 0;
  int         mismatches = 0;
  bit         steady     = 1'b0;

  function automatic void predict_drive(input logic signed [7:0] angle, input logic [11:0] kp_raw,
                                        input logic [11:0] ki_raw, input logic [11:0] kd_raw);
    longint     err, avg, p_term, d_term, v, hi, lo, lim;
    drive_res_t res;
    err = longint'(angle) - longint'(setpoint_cfg);
    if (err > 127) err = 127;
    else if (err < -128) err = -128;
    p_term = longint'(kp_raw) * err * 100;
    if (ki_raw >= 12'd2) begin
      // Trapezoidal mean of the two errors, truncated toward zero.
      avg = (err + err_prev) / 2;
      integ_acc = integ_acc + (longint'(ki_raw) * avg * PERIOD_MS) / 10;
      lim = longint'(bound_cfg) * UNIT;
      if (integ_acc > lim) integ_acc = lim;
      else if (integ_acc < -lim) integ_acc = -lim;
    end else begin
      integ_acc = 0;
    end
    d_term = (longint'(kd_raw) * (err - err_prev) * 100000) / PERIOD_MS;
    v = longint'(rest_cfg) * UNIT - (p_term + integ_acc + d_term);
    hi = longint'(upper_cfg) * UNIT;
    lo = longint'(lower_cfg) * UNIT;
    res.clamped = 1'b1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    else res.clamped = 1'b0;
    err_prev = err;
    res.level = v[21:0];
    drive_expected.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 75) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample driver: a beat stays on the bus until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (sample_if.valid && sample_if.ready)
        predict_drive(sample_if.angle_deg, sample_if.p_gain_raw, sample_if.i_gain_raw,
                      sample_if.d_gain_raw);
      if (!sample_if.valid || sample_if.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          sample_if.valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          next_item = sample_queue.pop_front();
          sample_if.valid <= 1'b1;
          sample_if.angle_deg <= next_item.angle;
          sample_if.p_gain_raw <= next_item.kp;
          sample_if.i_gain_raw <= next_item.ki;
          sample_if.d_gain_raw <= next_item.kd;
          send_gap <= pick_gap();
          if ($urandom_range(0, 199) == 0) steady <= !steady;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got_drive.level = result_if.drive_level;
        got_drive.clamped = result_if.drive_clamped;
        if (drive_expected.size() == 0) begin
          $error("result beat with no drive value pending: drive_level=%0d drive_clamped=%0b",
                 got_drive.level, got_drive.clamped);
          mismatches++;
        end else begin
          want_drive = drive_expected.pop_front();
          if (got_drive.level !== want_drive.level) begin
            $error("drive_level: expected %0d, actual %0d", want_drive.level, got_drive.level);
            mismatches++;
          end
          if (got_drive.clamped !== want_drive.clamped) begin
            $error("drive_clamped: expected %0b, actual %0b", want_drive.clamped,
                   got_drive.clamped);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        stall_left <= pick_stall();
      end
    end
  end

  task automatic add_sample(input logic [7:0] angle, input logic [11:0] kp,
                            input logic [11:0] ki, input logic [11:0] kd);
    sample_t s;
    s.angle = angle;
    s.kp = kp;
    s.ki = ki;
    s.kd = kd;
    sample_queue.push_back(s);
  endtask

  // Holds the sender back until every pending drive value has been seen.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || sample_if.valid || drive_expected.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input ptcd_pkg::cfg_reg_e idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ptcd_pkg::REG_SETPOINT: setpoint_cfg = val;
      ptcd_pkg::REG_REST:     rest_cfg = val;
      ptcd_pkg::REG_UPPER:    upper_cfg = val;
      ptcd_pkg::REG_LOWER:    lower_cfg = val;
      ptcd_pkg::REG_BOUND:    bound_cfg = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input int mode);
    int sp, rest, up, lo, bnd, tmp;
    case (mode)
      0: begin
        sp = 127; rest = 255; up = 255; lo = 0; bnd = 255;
      end
      1: begin
        sp = -128; rest = 0; up = 40; lo = 0; bnd = 0;
      end
      default: begin
        sp = $urandom_range(0, 255);
        rest = $urandom_range(0, 255);
        up = rest + $urandom_range(0, 40);
        lo = rest - $urandom_range(0, 40);
        if (up > 255) up = 255;
        if (lo < 0) lo = 0;
        // Now and then the clamp window is inverted.
        if ($urandom_range(0, 9) == 0) begin
          tmp = up; up = lo; lo = tmp;
        end
        bnd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
      end
    endcase
    write_reg(ptcd_pkg::REG_SETPOINT, sp[7:0]);
    write_reg(ptcd_pkg::REG_REST, rest[7:0]);
    write_reg(ptcd_pkg::REG_UPPER, up[7:0]);
    write_reg(ptcd_pkg::REG_LOWER, lo[7:0]);
    write_reg(ptcd_pkg::REG_BOUND, bnd[7:0]);
  endtask

  // Mostly beats that hover around the setpoint with modest gains, so the drive
  // leaves the clamps; the rest span the whole angle range, and a share of them the whole range of every field.
  task automatic run_random(input int count);
    int sel, ang, kp, ki, kd;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      ki = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 400);
      if (sel < 60) begin
        ang = $urandom_range(0, 24);
        ang = ang - 12 + setpoint_cfg;
        if (ang > 127) ang = 127;
        if (ang < -128) ang = -128;
        kp = $urandom_range(0, 300);
        kd = $urandom_range(0, 20);
      end else if (sel < 85) begin
        ang = $urandom_range(0, 255);
        kp = $urandom_range(0, 1000);
        kd = $urandom_range(0, 200);
      end else begin
        ang = $urandom_range(0, 255);
        kp = $urandom_range(0, 4095);
        ki = $urandom_range(0, 4095);
        kd = $urandom_range(0, 4095);
      end
      add_sample(ang[7:0], kp[11:0], ki[11:0], kd[11:0]);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = ptcd_pkg::REG_SETPOINT;
    cfg_data = 8'd0;
    sample_if.valid = 1'b0;
    sample_if.angle_deg = 8'sd0;
    sample_if.p_gain_raw = 12'd0;
    sample_if.i_gain_raw = 12'd0;
    sample_if.d_gain_raw = 12'd0;
    result_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: gain extremes, both clamps, integral enable and wind-up.
    add_sample(8'sd0, 12'd0, 12'd0, 12'd0);
    add_sample(8'sd1, 12'd100, 12'd0, 12'd0);
    add_sample(8'sd127, 12'd4095, 12'd4095, 12'd4095);
    add_sample(8'h80, 12'd4095, 12'd4095, 12'd4095);
    add_sample(8'h80, 12'd0, 12'd1, 12'd0);
    add_sample(8'sd10, 12'd0, 12'd2, 12'd0);
    add_sample(-8'sd3, 12'd0, 12'd3, 12'd0);
    add_sample(-8'sd4, 12'd0, 12'd7, 12'd0);
    add_sample(8'sd5, 12'd0, 12'd0, 12'd3);
    add_sample(-8'sd7, 12'd0, 12'd0, 12'd4095);
    add_sample(8'sd0, 12'd1, 12'd4095, 12'd1);
    add_sample(8'sd127, 12'd0, 12'd4095, 12'd0);
    add_sample(8'sd127, 12'd0, 12'd4095, 12'd0);
    add_sample(8'h80, 12'd0, 12'd4095, 12'd0);
    run_random(200);
    wait_idle();

    // Error saturating low, zero integral bound and an inverted clamp window.
    write_reg(ptcd_pkg::REG_SETPOINT, 8'sd127);
    write_reg(ptcd_pkg::REG_REST, 8'd10);
    write_reg(ptcd_pkg::REG_UPPER, 8'd20);
    write_reg(ptcd_pkg::REG_LOWER, 8'd250);
    write_reg(ptcd_pkg::REG_BOUND, 8'd0);
    add_sample(8'h80, 12'd0, 12'd0, 12'd0);
    add_sample(8'h80, 12'd10, 12'd4095, 12'd0);
    add_sample(8'sd127, 12'd0, 12'd0, 12'd0);
    wait_idle();

    // Error saturating high.
    write_reg(ptcd_pkg::REG_SETPOINT, 8'h80);
    write_reg(ptcd_pkg::REG_REST, 8'd0);
    write_reg(ptcd_pkg::REG_UPPER, 8'd100);
    write_reg(ptcd_pkg::REG_LOWER, 8'd50);
    add_sample(8'sd127, 12'd0, 12'd0, 12'd0);
    add_sample(8'h80, 12'd4095, 12'd4095, 12'd4095);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      apply_config(phase);
      run_random(215);
      wait_idle();
    end

    if (drive_expected.size() != 0) begin
      $error("%0d drive values never arrived", drive_expected.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### pid_trapezoid_clamped_drive.f
rtl/core/ptcd_pkg.sv
rtl/core/ptcd_in_if.sv
rtl/core/ptcd_out_if.sv
rtl/core/ptcd_cfg_regs.sv
rtl/core/ptcd_cdiv.sv
rtl/core/pid_trapezoid_clamped_drive.sv
sim/pid_trapezoid_clamped_drive_tb.sv
